FILE: design/mi4_pkg.sv
package mi4_pkg;

    localparam int ELEM_W   = 32;
    localparam int THR_W    = 31;
    localparam int ACC_W    = 136;
    localparam int COF_W    = 99;
    localparam int DABS_W   = 131;
    localparam int DIV_W    = 164;
    localparam int Q_W      = 35;
    localparam int DIV_LAST = 35;

    localparam logic [3:0] LAST_IDX = 4'd15;

    localparam logic [2:0] ADDR_THRESH = 3'd0;

    typedef enum logic [2:0] {
        A_HOLD,
        A_ELEM,
        A_PLO,
        A_PHI,
        A_COF
    } t_asel;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_COF,
        ST_CSTORE,
        ST_DET,
        ST_DSTORE,
        ST_SING,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        wr_en;
        logic [3:0]  addr;
        t_asel       a_sel;
        logic        b_ld;
        logic        mul;
        logic        acc_clr;
        logic        acc_add;
        logic        acc_neg;
        logic [1:0]  limb;
        logic [3:0]  cidx;
        logic        cof_st;
        logic        det_st;
        logic        sing_chk;
        logic        div_init;
        logic        div_step;
        logic        div_round;
        logic        out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic sing;
    } t_dp_stat;

endpackage

FILE: design/mi4_datapath.sv
module mi4_datapath
    import mi4_pkg::*;
(
    input  logic                     i_clk,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [ELEM_W-1:0] i_element,
    input  logic [THR_W-1:0]         i_thresh,
    output t_dp_stat                 o_stat,
    output logic signed [ELEM_W-1:0] o_value
);

    logic [ELEM_W-1:0]        r_store [16];
    logic [COF_W-1:0]         r_cof   [16];
    logic signed [ELEM_W:0]   r_a;
    logic signed [ELEM_W-1:0] r_b;
    logic signed [2*ELEM_W:0] r_prod;
    logic [2*ELEM_W-1:0]      r_pair;
    logic [ACC_W-1:0]         r_acc;
    logic [DABS_W-1:0]        r_dabs;
    logic                     r_dneg;
    logic                     r_sing;
    logic [DIV_W-1:0]         r_rem;
    logic [DIV_W-1:0]         r_dv;
    logic [Q_W-1:0]           r_q;
    logic                     r_qneg;
    logic [ELEM_W-1:0]        r_value;

    logic [ELEM_W-1:0] w_elem;
    logic [COF_W-1:0]  w_cof;
    logic [COF_W-1:0]  w_cabs;
    logic [ACC_W-1:0]  w_ext;
    logic [ACC_W-1:0]  w_sh;
    logic [ACC_W-1:0]  w_aabs;
    logic [DABS_W-1:0] w_lim;
    logic [ELEM_W:0]   w_cof_limb;
    logic              w_ge;
    logic [ELEM_W-1:0] w_quot;

    assign w_elem = r_store[i_cmd.addr];
    assign w_cof  = r_cof[i_cmd.cidx];
    assign w_cabs = w_cof[COF_W-1] ? -w_cof : w_cof;
    assign w_ext  = ACC_W'(r_prod);
    assign w_sh   = w_ext << {i_cmd.limb, 5'b0};
    assign w_aabs = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign w_lim  = DABS_W'({i_thresh, 48'b0});
    assign w_ge   = (r_rem >= r_dv);

    always_comb begin
        case (i_cmd.limb)
            2'd0:    w_cof_limb = {1'b0, w_cof[31:0]};
            2'd1:    w_cof_limb = {1'b0, w_cof[63:32]};
            2'd2:    w_cof_limb = {1'b0, w_cof[95:64]};
            default: w_cof_limb = {{30{w_cof[COF_W-1]}}, w_cof[COF_W-1:96]};
        endcase
    end

    // Round-to-nearest already folded into r_q; clamp to the Q16.16 range.
    always_comb begin
        if (!r_qneg) begin
            w_quot = (r_q > Q_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r_q[31:0];
        end else begin
            w_quot = (r_q > Q_W'(32'h8000_0000)) ? 32'h8000_0000 : -r_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_store[i_cmd.addr] <= i_element;
        end
        case (i_cmd.a_sel)
            A_ELEM:  r_a <= {w_elem[ELEM_W-1], w_elem};
            A_PLO: begin
                r_a    <= {1'b0, r_prod[31:0]};
                r_pair <= r_prod[2*ELEM_W-1:0];
            end
            A_PHI:   r_a <= {r_pair[2*ELEM_W-1], r_pair[2*ELEM_W-1:32]};
            A_COF:   r_a <= w_cof_limb;
            default: r_a <= r_a;
        endcase
        if (i_cmd.b_ld) begin
            r_b <= w_elem;
        end
        if (i_cmd.mul) begin
            r_prod <= r_a * r_b;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= i_cmd.acc_neg ? r_acc - w_sh : r_acc + w_sh;
        end
        if (i_cmd.cof_st) begin
            r_cof[i_cmd.cidx] <= r_acc[COF_W-1:0];
        end
        if (i_cmd.det_st) begin
            r_dneg <= r_acc[ACC_W-1];
            r_dabs <= w_aabs[DABS_W-1:0];
        end
        if (i_cmd.sing_chk) begin
            r_sing <= (r_dabs <= w_lim);
        end
        if (i_cmd.div_init) begin
            r_rem  <= DIV_W'({w_cabs, 32'b0});
            r_dv   <= {r_dabs, 33'b0};
            r_q    <= '0;
            r_qneg <= w_cof[COF_W-1] ^ r_dneg;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? r_rem - r_dv : r_rem;
            r_q   <= {r_q[Q_W-2:0], w_ge};
            r_dv  <= r_dv >> 1;
        end else if (i_cmd.div_round) begin
            if ({r_rem[DIV_W-2:0], 1'b0} >= DIV_W'(r_dabs)) begin
                r_q <= r_q + Q_W'(1);
            end
        end
        if (i_cmd.out_ld) begin
            r_value <= r_sing ? w_elem : w_quot;
        end
    end

    assign o_stat.sing = r_sing;
    assign o_value     = r_value;

endmodule

FILE: design/mi4_ctrl.sv
module mi4_ctrl
    import mi4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_position,
    output logic       o_singular,
    output logic       o_final_res,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [3:0] r_ci, n_ci;
    logic [2:0] r_term, n_term;
    logic [2:0] r_step, n_step;
    logic [1:0] r_limb, n_limb;
    logic [5:0] r_dstep, n_dstep;
    logic       r_oval, n_oval;
    logic [3:0] r_pos, n_pos;
    logic       r_osing, n_osing;
    logic       r_fin, n_fin;

    logic [1:0] w_row;
    logic [1:0] w_col;
    logic       w_neg;

    // Index j of a 3x3 minor mapped back to the 4x4 index, skipping s.
    function automatic logic [1:0] skip_idx(input logic [1:0] j, input logic [1:0] s);
        skip_idx = (j >= s) ? j + 2'd1 : j;
    endfunction

    // Column permutation of the six Leibniz terms; the last three are odd.
    function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] p);
        logic [5:0] cols;
        case (t)
            3'd0:    cols = {2'd2, 2'd1, 2'd0};
            3'd1:    cols = {2'd0, 2'd2, 2'd1};
            3'd2:    cols = {2'd1, 2'd0, 2'd2};
            3'd3:    cols = {2'd1, 2'd2, 2'd0};
            3'd4:    cols = {2'd0, 2'd1, 2'd2};
            default: cols = {2'd2, 2'd0, 2'd1};
        endcase
        perm_col = cols[2*p +: 2];
    endfunction

    function automatic logic [3:0] term_addr(input logic [1:0] r, input logic [1:0] c,
                                             input logic [2:0] t, input logic [1:0] p);
        term_addr = {skip_idx(p, r), skip_idx(perm_col(t, p), c)};
    endfunction

    assign w_row = r_ci[3:2];
    assign w_col = r_ci[1:0];
    assign w_neg = (r_term >= 3'd3) ^ (w_row[0] ^ w_col[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ci    <= '0;
            r_term  <= '0;
            r_step  <= '0;
            r_limb  <= '0;
            r_dstep <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ci    <= n_ci;
            r_term  <= n_term;
            r_step  <= n_step;
            r_limb  <= n_limb;
            r_dstep <= n_dstep;
            r_oval  <= n_oval;
        end
        r_pos   <= n_pos;
        r_osing <= n_osing;
        r_fin   <= n_fin;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ci    = r_ci;
        n_term  = r_term;
        n_step  = r_step;
        n_limb  = r_limb;
        n_dstep = r_dstep;
        n_oval  = r_oval && i_stall;
        n_pos   = r_pos;
        n_osing = r_osing;
        n_fin   = r_fin;
        o_stall = 1'b1;
        o_cmd   = '0;
        unique case (r_state)
            ST_LOAD: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.wr_en = 1'b1;
                    o_cmd.addr  = r_cnt;
                    n_cnt       = r_cnt + 4'd1;
                    if (r_cnt == LAST_IDX) begin
                        o_cmd.acc_clr = 1'b1;
                        n_state       = ST_COF;
                        n_ci          = '0;
                        n_term        = '0;
                        n_step        = '0;
                    end
                end
            end
            ST_COF: begin
                o_cmd.acc_neg = w_neg;
                n_step        = r_step + 3'd1;
                unique case (r_step)
                    3'd0: begin
                        o_cmd.a_sel = A_ELEM;
                        o_cmd.addr  = term_addr(w_row, w_col, r_term, 2'd0);
                    end
                    3'd1: begin
                        o_cmd.b_ld = 1'b1;
                        o_cmd.addr = term_addr(w_row, w_col, r_term, 2'd1);
                    end
                    3'd3: begin
                        o_cmd.a_sel = A_PLO;
                        o_cmd.b_ld  = 1'b1;
                        o_cmd.addr  = term_addr(w_row, w_col, r_term, 2'd2);
                    end
                    3'd5: begin
                        o_cmd.acc_add = 1'b1;
                        o_cmd.limb    = 2'd0;
                        o_cmd.a_sel   = A_PHI;
                    end
                    3'd7: begin
                        o_cmd.acc_add = 1'b1;
                        o_cmd.limb    = 2'd1;
                        if (r_term == 3'd5) begin
                            n_term  = '0;
                            n_state = ST_CSTORE;
                        end else begin
                            n_term = r_term + 3'd1;
                        end
                    end
                    default: o_cmd.mul = 1'b1;
                endcase
            end
            ST_CSTORE: begin
                o_cmd.cof_st  = 1'b1;
                o_cmd.cidx    = r_ci;
                o_cmd.acc_clr = 1'b1;
                n_ci          = r_ci + 4'd1;
                n_step        = '0;
                n_limb        = '0;
                n_state       = (r_ci == LAST_IDX) ? ST_DET : ST_COF;
            end
            ST_DET: begin
                unique case (r_step)
                    3'd0: begin
                        o_cmd.a_sel = A_COF;
                        o_cmd.cidx  = {2'b00, w_col};
                        o_cmd.limb  = r_limb;
                        o_cmd.b_ld  = 1'b1;
                        o_cmd.addr  = {2'b00, w_col};
                        n_step      = 3'd1;
                    end
                    3'd1: begin
                        o_cmd.mul = 1'b1;
                        n_step    = 3'd2;
                    end
                    default: begin
                        o_cmd.acc_add = 1'b1;
                        o_cmd.limb    = r_limb;
                        n_step        = '0;
                        n_limb        = r_limb + 2'd1;
                        if (r_limb == 2'd3) begin
                            n_ci = r_ci + 4'd1;
                            if (w_col == 2'd3) begin
                                n_state = ST_DSTORE;
                            end
                        end
                    end
                endcase
            end
            ST_DSTORE: begin
                o_cmd.det_st = 1'b1;
                n_state      = ST_SING;
            end
            ST_SING: begin
                o_cmd.sing_chk = 1'b1;
                n_dstep        = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                if (i_stat.sing) begin
                    n_state = ST_EMIT;
                end else if (r_dstep == 6'd0) begin
                    o_cmd.div_init = 1'b1;
                    o_cmd.cidx     = {r_cnt[1:0], r_cnt[3:2]};
                    n_dstep        = 6'd1;
                end else if (r_dstep == 6'(DIV_LAST)) begin
                    o_cmd.div_round = 1'b1;
                    n_dstep         = '0;
                    n_state         = ST_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_dstep        = r_dstep + 6'd1;
                end
            end
            ST_EMIT: begin
                if (!r_oval || !i_stall) begin
                    o_cmd.out_ld = 1'b1;
                    o_cmd.addr   = r_cnt;
                    n_oval       = 1'b1;
                    n_pos        = r_cnt;
                    n_fin        = (r_cnt == LAST_IDX);
                    n_osing      = i_stat.sing;
                    n_cnt        = r_cnt + 4'd1;
                    n_state      = (r_cnt == LAST_IDX) ? ST_LOAD : ST_DIV;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_valid     = r_oval;
    assign o_position  = r_pos;
    assign o_singular  = r_osing;
    assign o_final_res = r_fin;

endmodule

FILE: design/matrix4x4_inverse.sv
// Loading takes one beat per cycle; the sixteenth beat starts the solve.
// Solve: cofactor products and then the determinant on one 33x32 multiplier,
// then restoring division per element of a non-singular matrix.
// One matrix at a time.
// Synchronous active-low reset clears control state and sets the threshold to 1.
module matrix4x4_inverse
    import mi4_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [ELEM_W-1:0] i_element,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [ELEM_W-1:0] o_value,
    output logic [3:0]               o_position,
    output logic                     o_singular,
    output logic                     o_final_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [THR_W-1:0] r_thresh;
    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THR_W'(1);
        end else if (psel && penable && pwrite && paddr == ADDR_THRESH) begin
            r_thresh <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_THRESH) ? {1'b0, r_thresh} : 32'b0;

    mi4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_position  (o_position),
        .o_singular  (o_singular),
        .o_final_res (o_final_res),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    mi4_datapath u_datapath (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_element (i_element),
        .i_thresh  (r_thresh),
        .o_stat    (w_stat),
        .o_value   (o_value)
    );

endmodule
